// ----- hdl/cts_pkg.sv -----
// Shared types, constants and helpers for the Cholesky triangular solver.
package cts_pkg;

	localparam int unsigned MAX_DIM_DEF   = 16;
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned DATA_W        = 32;
	localparam int unsigned IDX_W         = 4;
	localparam int unsigned DIM_W         = 5;
	localparam int unsigned OP_W          = 2;
	localparam int unsigned ACC_W         = 64;
	localparam int unsigned DIM_CAP_LIMIT = 16;
	localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_WR_FACTOR = 2'd0,
		OP_WR_RHS    = 2'd1,
		OP_SOLVE     = 2'd2,
		OP_BACK      = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_DIAG,
		ST_MAC_RD,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_STORE,
		ST_OUT_RD,
		ST_OUT_SEND
	} state_t;

	// Saturate a wide signed value to the 32-bit data range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sh7FFF_FFFF);
		lo = -ACC_W'(64'sh8000_0000);
		if (v > hi) return DATA_W'(32'h7FFF_FFFF);
		if (v < lo) return DATA_W'(32'h8000_0000);
		return v[DATA_W-1:0];
	endfunction

endpackage

// ----- hdl/cts_if.sv -----
// Valid/ready stream interfaces for solver input and output items.
interface cts_in_if;
	logic                          valid;
	logic                          ready;
	logic [cts_pkg::OP_W-1:0]      operation;
	logic [cts_pkg::IDX_W-1:0]     row_index;
	logic [cts_pkg::IDX_W-1:0]     col_index;
	logic signed [cts_pkg::DATA_W-1:0] data_value;
	modport source (output valid, operation, row_index, col_index, data_value, input ready);
	modport sink (input valid, operation, row_index, col_index, data_value, output ready);
endinterface

interface cts_out_if;
	logic                          valid;
	logic                          ready;
	logic [cts_pkg::IDX_W-1:0]     out_index;
	logic signed [cts_pkg::DATA_W-1:0] solution_value;
	logic                          zero_pivot;
	logic                          last;
	modport source (output valid, out_index, solution_value, zero_pivot, last, input ready);
	modport sink (input valid, out_index, solution_value, zero_pivot, last, output ready);
endinterface

// ----- hdl/cts_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module cts_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/cts_div.sv -----
// Restoring divider, one quotient bit per cycle, truncating toward zero with saturation.
module cts_div #(
	parameter int unsigned FRAC_BITS = cts_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [cts_pkg::ACC_W-1:0]      num,
	input  logic signed [cts_pkg::DATA_W-1:0]     den,
	output logic                                  done,
	output logic signed [cts_pkg::DATA_W-1:0]     quot,
	output logic                                  zero_den
);
	localparam int unsigned NW  = 63;
	localparam int unsigned CW  = $clog2(NW + 1);
	localparam logic [CW-1:0] LAST = CW'(NW - 1);

	logic            busy_q;
	logic [CW-1:0]   cnt_q;
	logic [NW-1:0]   dvd_q;
	logic [NW-1:0]   qt_q;
	logic [32:0]     rem_q;
	logic [31:0]     dmag_q;
	logic            neg_q;
	logic            sat_q;
	logic            satneg_q;
	logic            zero_q;

	logic [cts_pkg::ACC_W-1:0] nmag;
	logic [32:0]               dmag;
	logic signed [cts_pkg::ACC_W-1:0] lim;
	logic [33:0]               trial;
	logic [32:0]               shifted;
	logic signed [cts_pkg::ACC_W-1:0] qs;

	assign lim  = cts_pkg::ACC_W'(64'sd1) <<< (62 - FRAC_BITS);
	assign nmag = num[cts_pkg::ACC_W-1] ? cts_pkg::ACC_W'(-num) : num;
	assign dmag = den[cts_pkg::DATA_W-1] ? 33'(-{den[31], den}) : {1'b0, den};
	assign shifted = {rem_q[31:0], dvd_q[NW-1]};
	assign trial   = {1'b0, shifted} - {2'b0, dmag_q};

	// Start latches operands; special cases short-circuit to a saturated result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (sat_q || zero_q || cnt_q == LAST) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// Magnitude of num << FRAC_BITS fits 63 bits because |num| < 2^(62-F).
			dvd_q    <= NW'(nmag << FRAC_BITS);
			qt_q     <= '0;
			rem_q    <= '0;
			dmag_q   <= dmag[31:0] == 32'd0 && dmag[32] ? 32'h8000_0000 : dmag[31:0];
			neg_q    <= num[cts_pkg::ACC_W-1] ^ den[cts_pkg::DATA_W-1];
			zero_q   <= den == '0;
			satneg_q <= den == '0 ? num[cts_pkg::ACC_W-1]
				: (num[cts_pkg::ACC_W-1] ^ den[cts_pkg::DATA_W-1]);
			sat_q    <= (num >= lim) || (num <= -lim);
		end else if (busy_q && !sat_q && !zero_q) begin
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				qt_q  <= {qt_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				qt_q  <= {qt_q[NW-2:0], 1'b0};
			end
		end
	end

	assign qs = neg_q ? -cts_pkg::ACC_W'({1'b0, qt_q}) : cts_pkg::ACC_W'({1'b0, qt_q});
	assign quot = (sat_q || zero_q) ? (satneg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
		: cts_pkg::sat32(qs);
	assign zero_den = zero_q;
endmodule

// ----- hdl/cholesky_triangular_solve.sv -----
// Top level of the Cholesky triangular solver.
// Load items (factor or right-hand-side writes) are taken one per cycle. A solve walks the
// stored triangle one product at a time: each term passes through a memory read, a multiply
// and an accumulate state, and each row adds a divide plus control states. A full solve runs
// a forward pass and then a backward pass; a backward solve runs only the latter. Both end
// with n output transfers. No item is accepted while a solve is running or results are
// draining. The factor, right-hand side and work vector sit in synchronous RAMs.
module cholesky_triangular_solve #(
	parameter int unsigned MAX_DIM   = cts_pkg::MAX_DIM_DEF,
	parameter int unsigned FRAC_BITS = cts_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cts_pkg::DIM_W-1:0]  cfg_wdata,
	cts_in_if.sink                     in_ch,
	cts_out_if.source                  out_ch
);
	localparam int unsigned AW  = $clog2(MAX_DIM);
	localparam int unsigned FAW = 2 * AW;
	localparam int unsigned CAP = MAX_DIM < cts_pkg::DIM_CAP_LIMIT ? MAX_DIM
		: cts_pkg::DIM_CAP_LIMIT;
	localparam int unsigned DW  = cts_pkg::DATA_W;
	localparam int unsigned XW  = cts_pkg::ACC_W;

	cts_pkg::state_t state_q, state_d;

	logic [cts_pkg::DIM_W-1:0] dim_q;
	logic [AW:0]   n_q;
	logic [AW-1:0] i_q, j_q;
	logic          full_q;      // solve item is full mode
	logic          fwd_q;       // currently in forward pass
	logic          zp_q;
	logic signed [XW-1:0] acc_q;
	logic signed [2*DW-1:0] prod_s2;
	logic signed [DW-1:0]   diag_q;

	// RAM ports
	logic          f_we, r_we, w_we;
	logic [FAW-1:0] f_wa, f_ra;
	logic [AW-1:0]  r_wa, r_ra, w_wa, w_ra;
	logic [DW-1:0]  f_wd, r_wd, w_wd, f_rd, r_rd, w_rd;

	logic          div_start, div_done, div_zero;
	logic signed [DW-1:0] div_q;

	logic in_xfer;
	logic [AW:0] n_now;
	assign in_xfer = in_ch.valid && in_ch.ready;

	cts_ram #(.WIDTH(DW), .DEPTH(1 << FAW)) u_factor (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
	cts_ram #(.WIDTH(DW), .DEPTH(MAX_DIM)) u_rhs (
		.clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
	cts_ram #(.WIDTH(DW), .DEPTH(MAX_DIM)) u_work (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));

	cts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(acc_q), .den(diag_q),
		.done(div_done), .quot(div_q), .zero_den(div_zero));

	// Clamp dimension to [1, CAP].
	always_comb begin
		if (dim_q == '0) n_now = (AW+1)'(1);
		else if (32'(dim_q) > CAP) n_now = (AW+1)'(CAP);
		else n_now = (AW+1)'(dim_q);
	end

	// Load writes; indices of MAX_DIM or more are dropped.
	logic row_ok, col_ok;
	assign row_ok = 32'(in_ch.row_index) < MAX_DIM;
	assign col_ok = 32'(in_ch.col_index) < MAX_DIM;
	assign f_we = in_xfer && in_ch.operation == cts_pkg::OP_WR_FACTOR && row_ok && col_ok;
	assign f_wa = {AW'(in_ch.row_index), AW'(in_ch.col_index)};
	assign f_wd = in_ch.data_value;
	assign r_we = in_xfer && in_ch.operation == cts_pkg::OP_WR_RHS && row_ok;
	assign r_wa = AW'(in_ch.row_index);
	assign r_wd = in_ch.data_value;

	// Source of the sum's start term: rhs, or the forward result in the back pass of full mode.
	logic use_work_init;
	assign use_work_init = full_q && !fwd_q;

	// Read addresses: diagonal R[i][i] as a row starts, then R[j][i] forward, R[i][j] backward.
	// The work RAM keeps entry i addressed while a result is offered, so its data holds.
	always_comb begin
		r_ra = i_q;
		w_ra = (state_q == cts_pkg::ST_INIT || state_q == cts_pkg::ST_OUT_RD
			|| state_q == cts_pkg::ST_OUT_SEND) ? i_q : j_q;
		if (state_q == cts_pkg::ST_INIT) f_ra = {i_q, i_q};
		else if (fwd_q) f_ra = {j_q, i_q};
		else f_ra = {i_q, j_q};
	end

	// Forward pass terms j=0..i-1; backward pass terms j=n-1 down to i+1.
	logic has_terms;
	assign has_terms = fwd_q ? (i_q != '0) : ((AW+1)'(i_q) != n_q - (AW+1)'(1));

	logic signed [XW-1:0] rnd;
	assign rnd = (XW'(prod_s2) + (XW'(64'sd1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

	logic last_term;
	assign last_term = fwd_q ? ((AW+1)'(j_q) + (AW+1)'(1) == (AW+1)'(i_q))
		: ((AW+1)'(j_q) == (AW+1)'(i_q) + (AW+1)'(1));

	assign w_we = state_q == cts_pkg::ST_STORE;
	assign w_wa = i_q;
	assign w_wd = div_q;
	assign div_start = state_q == cts_pkg::ST_DIV_START;
	assign in_ch.ready = state_q == cts_pkg::ST_IDLE;

	logic out_v_q;
	logic [cts_pkg::IDX_W-1:0] out_idx_q;
	logic out_last_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.out_index = out_idx_q;
	assign out_ch.solution_value = w_rd;
	assign out_ch.zero_pivot = zp_q;
	assign out_ch.last = out_last_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cts_pkg::ST_IDLE: begin
				if (in_xfer && (in_ch.operation == cts_pkg::OP_SOLVE
						|| in_ch.operation == cts_pkg::OP_BACK))
					state_d = cts_pkg::ST_INIT;
			end
			cts_pkg::ST_INIT:      state_d = cts_pkg::ST_DIAG;
			cts_pkg::ST_DIAG:      state_d = has_terms ? cts_pkg::ST_MAC_RD
				: cts_pkg::ST_DIV_START;
			cts_pkg::ST_MAC_RD:    state_d = cts_pkg::ST_MAC_MUL;
			cts_pkg::ST_MAC_MUL:   state_d = cts_pkg::ST_MAC_ACC;
			cts_pkg::ST_MAC_ACC:   state_d = last_term ? cts_pkg::ST_DIV_START
				: cts_pkg::ST_MAC_RD;
			cts_pkg::ST_DIV_START: state_d = cts_pkg::ST_DIV_RUN;
			cts_pkg::ST_DIV_RUN:   if (div_done) state_d = cts_pkg::ST_STORE;
			cts_pkg::ST_STORE: begin
				if (fwd_q) state_d = ((AW+1)'(i_q) == n_q - (AW+1)'(1))
					? cts_pkg::ST_INIT : cts_pkg::ST_INIT;
				else state_d = (i_q == '0) ? cts_pkg::ST_OUT_RD : cts_pkg::ST_INIT;
			end
			cts_pkg::ST_OUT_RD:    state_d = cts_pkg::ST_OUT_SEND;
			cts_pkg::ST_OUT_SEND: begin
				if (out_ch.ready) state_d = out_last_q ? cts_pkg::ST_IDLE
					: cts_pkg::ST_OUT_RD;
			end
			default: state_d = cts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cts_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q   <= cts_pkg::DIM_RESET;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			full_q  <= 1'b0;
			fwd_q   <= 1'b0;
			zp_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) dim_q <= cfg_wdata;
			case (state_q)
				cts_pkg::ST_IDLE: if (state_d == cts_pkg::ST_INIT) begin
					n_q    <= n_now;
					full_q <= in_ch.operation == cts_pkg::OP_SOLVE;
					fwd_q  <= in_ch.operation == cts_pkg::OP_SOLVE;
					zp_q   <= 1'b0;
					i_q    <= in_ch.operation == cts_pkg::OP_SOLVE ? '0
						: AW'(n_now - (AW+1)'(1));
				end
				cts_pkg::ST_DIAG:
					j_q <= fwd_q ? '0 : AW'(n_q - (AW+1)'(1));
				cts_pkg::ST_MAC_ACC:
					j_q <= fwd_q ? j_q + AW'(1) : j_q - AW'(1);
				cts_pkg::ST_DIV_RUN:
					if (div_done && div_zero) zp_q <= 1'b1;
				cts_pkg::ST_STORE: begin
					if (fwd_q) begin
						if ((AW+1)'(i_q) == n_q - (AW+1)'(1)) fwd_q <= 1'b0;
						else i_q <= i_q + AW'(1);
					end else if (i_q != '0) begin
						i_q <= i_q - AW'(1);
					end
				end
				cts_pkg::ST_OUT_RD: out_v_q <= 1'b1;
				cts_pkg::ST_OUT_SEND: if (out_ch.ready) begin
					out_v_q <= 1'b0;
					i_q     <= i_q + AW'(1);
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			cts_pkg::ST_DIAG:
				acc_q <= use_work_init ? XW'($signed(w_rd)) : XW'($signed(r_rd));
			cts_pkg::ST_MAC_MUL: prod_s2 <= $signed(w_rd) * $signed(f_rd);
			cts_pkg::ST_MAC_ACC: acc_q <= acc_q - rnd;
			default: ;
		endcase
		if (state_q == cts_pkg::ST_DIAG) diag_q <= f_rd;
		if (state_q == cts_pkg::ST_OUT_SEND && out_ch.ready) begin
			out_idx_q <= cts_pkg::IDX_W'(i_q + AW'(1));
		end
		if (state_q == cts_pkg::ST_OUT_RD) begin
			out_idx_q  <= cts_pkg::IDX_W'(i_q);
			out_last_q <= (AW+1)'(i_q) == n_q - (AW+1)'(1);
		end
	end

`ifndef SYNTHESIS
	// No input accepted while results are pending.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input accepted during drain");
	// Output payload holds while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.solution_value))
		else $error("output changed while stalled");
	// Divider only started from its start state.
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == cts_pkg::ST_DIV_RUN) else $error("divider misstep");
`endif
endmodule

// ----- tb/tb_cts_if.sv -----
// Testbench helper package: the record of one expected solution entry.
`timescale 1ns / 100ps
package tb_cts_util;
	typedef struct packed {
		logic [cts_pkg::IDX_W-1:0]         idx;
		logic signed [cts_pkg::DATA_W-1:0] value;
		logic                              zp;
		logic                              last;
	} solution_t;
endpackage

// ----- tb/tb.sv -----
// Self-checking testbench for the Cholesky triangular solver: loads, solves, random traffic.
`timescale 1ns / 100ps
module tb;
	localparam int MAXD = 16;
	localparam int FB = 16;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam int IDLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [cts_pkg::DIM_W-1:0] cfg_wdata = '0;

	cts_in_if in_ch ();
	cts_out_if out_ch ();

	cholesky_triangular_solve u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	longint factor_m [MAXD*MAXD];
	longint rhs_m [MAXD];
	longint work_m [MAXD];
	bit factor_set [MAXD*MAXD];
	bit rhs_set [MAXD];
	int dim_m = 16;
	tb_cts_util::solution_t solutions_due[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;

	function automatic longint sat_q(longint v);
		if (v > QMAX) return QMAX;
		if (v < QMIN) return QMIN;
		return v;
	endfunction

	// product rounded to nearest, ties up (arithmetic shift is floor)
	function automatic longint mul_round(longint a, longint b);
		longint p;
		p = a * b + (64'sd1 <<< (FB-1));
		return p >>> FB;
	endfunction

	function automatic longint div_trunc(longint s, longint d, ref bit zp);
		longint lim;
		lim = 64'sd1 <<< (62-FB);
		if (d == 0) begin
			zp = 1'b1;
			return (s < 0) ? QMIN : QMAX;
		end
		if (s >= lim || s <= -lim) return ((s < 0) != (d < 0)) ? QMIN : QMAX;
		return sat_q((s * (64'sd1 <<< FB)) / d);
	endfunction

	function automatic int dim_used();
		int n;
		n = dim_m;
		if (n < 1) n = 1;
		if (n > MAXD) n = MAXD;
		return n;
	endfunction

	task automatic backsub(int n, longint src[MAXD], ref bit zp);
		longint s;
		for (int i = n-1; i >= 0; i--) begin
			s = src[i];
			for (int j = n-1; j > i; j--) s -= mul_round(work_m[j], factor_m[i*MAXD+j]);
			work_m[i] = div_trunc(s, factor_m[i*MAXD+i], zp);
		end
	endtask

	// apply one item to the predictor and queue the solution entries it causes
	task automatic predict_item(cts_pkg::op_t op, int row, int col, logic signed [31:0] val);
		int n;
		bit zp;
		longint s;
		longint tmp[MAXD];
		tb_cts_util::solution_t r;
		zp = 1'b0;
		case (op)
			cts_pkg::OP_WR_FACTOR: begin
				factor_m[row*MAXD+col] = val;
				factor_set[row*MAXD+col] = 1'b1;
			end
			cts_pkg::OP_WR_RHS: begin
				rhs_m[row] = val;
				rhs_set[row] = 1'b1;
			end
			default: begin
				n = dim_used();
				if (op == cts_pkg::OP_SOLVE) begin
					for (int i = 0; i < n; i++) begin
						s = rhs_m[i];
						for (int j = 0; j < i; j++) s -= mul_round(work_m[j], factor_m[j*MAXD+i]);
						work_m[i] = div_trunc(s, factor_m[i*MAXD+i], zp);
					end
					tmp = work_m;
					backsub(n, tmp, zp);
				end else begin
					tmp = rhs_m;
					backsub(n, tmp, zp);
				end
				for (int i = 0; i < n; i++) begin
					r.idx = i[3:0];
					r.value = work_m[i][31:0];
					r.zp = zp;
					r.last = (i == n-1);
					solutions_due.insert(solutions_due.size(), r);
				end
			end
		endcase
	endtask

	function automatic int rand_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	// one transfer on the input channel; valid stays up only for a back-to-back follower
	task automatic send_item(cts_pkg::op_t op, int row, int col, logic signed [31:0] val);
		int gap;
		gap = rand_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.row_index <= row[3:0];
		in_ch.col_index <= col[3:0];
		in_ch.data_value <= val;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_item(op, row, col, val);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (!arst_n || hold_off) out_ch.ready <= 1'b0;
		else out_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	// checker
	always @(posedge clk) begin
		tb_cts_util::solution_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (solutions_due.size() == 0) begin
				report_mismatch("unexpected result, out_index", out_ch.out_index, -1);
			end else begin
				w = solutions_due.pop_front();
				if (out_ch.out_index !== w.idx) report_mismatch("out_index", out_ch.out_index, w.idx);
				if (out_ch.solution_value !== w.value)
					report_mismatch("solution_value", out_ch.solution_value, w.value);
				if (out_ch.zero_pivot !== w.zp) report_mismatch("zero_pivot", out_ch.zero_pivot, w.zp);
				if (out_ch.last !== w.last) report_mismatch("last", out_ch.last, w.last);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL cholesky_triangular_solve");
			$finish;
		end
	end

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (solutions_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_dim(int d);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= d[4:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		dim_m = int'(d[4:0]);
	endtask

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom();
			default: return $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh00020000;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_diag();
		case ($urandom_range(0, 19))
			0: return 32'sh0;
			1: return $urandom();
			default: return $urandom_range(32'h8000, 32'h40000) * ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	// load upper triangle and rhs for size n
	task automatic load_system(int n);
		for (int i = 0; i < n; i++) begin
			send_item(cts_pkg::OP_WR_RHS, i, $urandom_range(0, 15), rand_val());
			for (int j = i; j < n; j++)
				send_item(cts_pkg::OP_WR_FACTOR, i, j, (i == j) ? rand_diag() : rand_val());
		end
	endtask

	// every row has been written up to n, so a solve is legal
	function automatic bit solvable(int n);
		for (int i = 0; i < n; i++) begin
			if (!rhs_set[i]) return 1'b0;
			for (int j = i; j < n; j++) if (!factor_set[i*MAXD+j]) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic test_directed();
		set_dim(1);
		send_item(cts_pkg::OP_WR_FACTOR, 0, 0, 32'sh00010000);
		send_item(cts_pkg::OP_WR_RHS, 0, 5, 32'sh7FFFFFFF);
		send_item(cts_pkg::OP_SOLVE, 0, 0, 32'sh0);
		send_item(cts_pkg::OP_BACK, 15, 15, 32'shFFFFFFFF);
		send_item(cts_pkg::OP_WR_FACTOR, 0, 0, 32'sh0);
		send_item(cts_pkg::OP_BACK, 0, 0, 32'sh0);
		send_item(cts_pkg::OP_WR_RHS, 0, 0, 32'sh80000000);
		send_item(cts_pkg::OP_SOLVE, 0, 0, 32'sh0);
		send_item(cts_pkg::OP_WR_FACTOR, 15, 0, 32'sh12345678);
		send_item(cts_pkg::OP_WR_FACTOR, 0, 0, 32'sh00000001);
		send_item(cts_pkg::OP_BACK, 0, 0, 32'sh0);
		set_dim(2);
		send_item(cts_pkg::OP_WR_FACTOR, 0, 1, 32'sh7FFFFFFF);
		send_item(cts_pkg::OP_WR_FACTOR, 1, 1, 32'sh80000000);
		send_item(cts_pkg::OP_WR_FACTOR, 1, 0, 32'sh55555555);
		send_item(cts_pkg::OP_WR_RHS, 1, 0, 32'sh00030000);
		send_item(cts_pkg::OP_SOLVE, 0, 0, 32'sh0);
		send_item(cts_pkg::OP_BACK, 0, 0, 32'sh0);
		set_dim(0);
		send_item(cts_pkg::OP_BACK, 0, 0, 32'sh0);
	endtask

	task automatic test_full_size();
		set_dim(16);
		load_system(16);
		send_item(cts_pkg::OP_SOLVE, 0, 0, 32'sh0);
		send_item(cts_pkg::OP_BACK, 0, 0, 32'sh0);
		set_dim(31);
		send_item(cts_pkg::OP_BACK, 0, 0, 32'sh0);
	endtask

	// hold the receiver off while solves pile up at the input
	task automatic test_backpressure();
		set_dim(3);
		load_system(3);
		hold_off = 1'b1;
		fork
			begin
				send_item(cts_pkg::OP_BACK, 0, 0, 32'sh0);
				send_item(cts_pkg::OP_SOLVE, 0, 0, 32'sh0);
				in_ch.valid <= 1'b0;
			end
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
		join
	endtask

	task automatic test_random();
		int n;
		int op;
		for (int k = 0; k < 40; k++) begin
			if (k % 10 == 0) begin
				n = (k == 20) ? 12 : $urandom_range(1, 5);
				set_dim(n);
				load_system(n);
			end
			n = dim_used();
			op = $urandom_range(0, 9);
			if (op < 4) send_item(cts_pkg::OP_WR_FACTOR, $urandom_range(0, 15),
				$urandom_range(0, 15), rand_val());
			else if (op < 6) send_item(cts_pkg::OP_WR_RHS, $urandom_range(0, n-1),
				$urandom_range(0, 15), rand_val());
			else if (op == 6) send_item(cts_pkg::OP_WR_FACTOR, $urandom_range(0, n-1),
				$urandom_range(0, n-1), rand_diag());
			if (solvable(n)) send_item($urandom_range(0, 1) ? cts_pkg::OP_SOLVE : cts_pkg::OP_BACK,
				$urandom(), $urandom(), $urandom());
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.operation = '0;
		in_ch.row_index = '0;
		in_ch.col_index = '0;
		in_ch.data_value = '0;
		for (int i = 0; i < MAXD*MAXD; i++) factor_set[i] = 1'b0;
		for (int i = 0; i < MAXD; i++) rhs_set[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_size();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0) $display("PASS cholesky_triangular_solve");
		else $display("FAIL cholesky_triangular_solve");
		$finish;
	end
endmodule

// ----- files.f -----
hdl/cts_pkg.sv
hdl/cts_if.sv
hdl/cts_ram.sv
hdl/cts_div.sv
hdl/cholesky_triangular_solve.sv
tb/tb_cts_if.sv
tb/tb.sv
